>>> design/mppt_po_pkg.sv
package mppt_po_pkg;

  // Field widths
  localparam int unsigned DUTY_W     = 11;
  localparam int unsigned POWER_W    = 24;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned MA_W       = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Converter self consumption and guess margin
  localparam logic [MA_W:0] SELF_MA      = 17'd10;
  localparam int unsigned   GUESS_MARGIN = 4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_MV        = 3'd0,
    REG_TARGET_MA        = 3'd1,
    REG_STOP_PANEL_MA    = 3'd2,
    REG_LOW_SUN_PANEL_MA = 3'd3,
    REG_DUTY_STEP        = 3'd4,
    REG_RESTART_DELAY_S  = 3'd5,
    REG_INIT_OFFSET      = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [MV_W-1:0]     RST_TARGET_MV        = 16'd14400;
  localparam logic [MA_W-1:0]     RST_TARGET_MA        = 16'd20000;
  localparam logic [MA_W-1:0]     RST_STOP_PANEL_MA    = 16'd20;
  localparam logic [MA_W-1:0]     RST_LOW_SUN_PANEL_MA = 16'd100;
  localparam logic [STEP_W-1:0]   RST_DUTY_STEP        = 7'd1;
  localparam logic [TIME_W/2-1:0] RST_RESTART_DELAY_S  = 16'd60;
  localparam logic [OFFSET_W-1:0] RST_INIT_OFFSET      = 8'd0;

  typedef struct packed {
    logic [MV_W-1:0]     target_mv;
    logic [MA_W-1:0]     target_ma;
    logic [MA_W-1:0]     stop_panel_ma;
    logic [MA_W-1:0]     low_sun_panel_ma;
    logic [STEP_W-1:0]   duty_step;
    logic [TIME_W/2-1:0] restart_delay_s;
    logic [OFFSET_W-1:0] init_offset;
  } cfg_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

>>> design/mppt_po_cfg.sv
module mppt_po_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mppt_po_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mppt_po_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mppt_po_pkg::cfg_t                     cfg
);

  // Take writes whenever reset is released
  assign cfg_ready = !rst;

  // Write one register per transfer; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_mv        <= mppt_po_pkg::RST_TARGET_MV;
      cfg.target_ma        <= mppt_po_pkg::RST_TARGET_MA;
      cfg.stop_panel_ma    <= mppt_po_pkg::RST_STOP_PANEL_MA;
      cfg.low_sun_panel_ma <= mppt_po_pkg::RST_LOW_SUN_PANEL_MA;
      cfg.duty_step        <= mppt_po_pkg::RST_DUTY_STEP;
      cfg.restart_delay_s  <= mppt_po_pkg::RST_RESTART_DELAY_S;
      cfg.init_offset      <= mppt_po_pkg::RST_INIT_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mppt_po_pkg::cfg_reg_t'(cfg_index))
        mppt_po_pkg::REG_TARGET_MV:        cfg.target_mv        <= cfg_data;
        mppt_po_pkg::REG_TARGET_MA:        cfg.target_ma        <= cfg_data;
        mppt_po_pkg::REG_STOP_PANEL_MA:    cfg.stop_panel_ma    <= cfg_data;
        mppt_po_pkg::REG_LOW_SUN_PANEL_MA: cfg.low_sun_panel_ma <= cfg_data;
        mppt_po_pkg::REG_DUTY_STEP:
          cfg.duty_step <= cfg_data[mppt_po_pkg::STEP_W-1:0];
        mppt_po_pkg::REG_RESTART_DELAY_S:  cfg.restart_delay_s  <= cfg_data;
        mppt_po_pkg::REG_INIT_OFFSET:
          cfg.init_offset <= cfg_data[mppt_po_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/mppt_po_datapath.sv
module mppt_po_datapath #(
  parameter int unsigned DUTY_TOP = 1024,
  parameter int unsigned DUTY_MAX = 1016,
  parameter int unsigned DUTY_MIN = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mppt_po_pkg::cfg_t                   cfg,
  input  mppt_po_pkg::dp_cmd_t                cmd,
  output mppt_po_pkg::dp_status_t             status,
  input  logic [mppt_po_pkg::POWER_W-1:0]     panel_power_mw,
  input  logic [mppt_po_pkg::MV_W-1:0]        battery_mv,
  input  logic [mppt_po_pkg::MV_W-1:0]        panel_mv,
  input  logic [mppt_po_pkg::MA_W-1:0]        panel_ma,
  input  logic [mppt_po_pkg::MA_W-1:0]        charge_ma,
  input  logic                                overtemp,
  input  logic [mppt_po_pkg::TIME_W-1:0]      now_s,
  output logic [mppt_po_pkg::DUTY_W-1:0]      duty,
  output logic                                charging,
  output logic                                dir_up
);

  localparam int unsigned DW     = mppt_po_pkg::DUTY_W;
  localparam int unsigned MW     = mppt_po_pkg::MV_W;
  localparam int unsigned TOP_W  = $clog2(DUTY_TOP + 1);
  localparam int unsigned PROD_W = MW + TOP_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned CNT_W  = $clog2(PROD_W);
  localparam int unsigned CMP_W  = 17;

  localparam logic [CMP_W-1:0] MAX_C     = CMP_W'(DUTY_MAX);
  localparam logic [CMP_W-1:0] MIN_C     = CMP_W'(DUTY_MIN);
  localparam logic [CMP_W-1:0] GUESS_LIM = CMP_W'(DUTY_MAX - mppt_po_pkg::GUESS_MARGIN);

  // Latched measurement
  logic [mppt_po_pkg::POWER_W-1:0] power_r;
  logic [MW-1:0]                   bat_r;
  logic [MW-1:0]                   pan_r;
  logic [mppt_po_pkg::MA_W-1:0]    pan_ma_r;
  logic [mppt_po_pkg::MA_W-1:0]    chg_ma_r;
  logic                            hot_r;
  logic [mppt_po_pkg::TIME_W-1:0]  now_r;
  logic [PROD_W-1:0]               prod;

  // Divider
  logic [MW-1:0]     rem;
  logic [PROD_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [MW:0]       shifted;
  logic [MW:0]       trial;

  // Controller state
  logic                            charging_on;
  logic [DW-1:0]                   duty_reg;
  logic [mppt_po_pkg::POWER_W-1:0] last_power;
  logic                            climb_up;
  logic [mppt_po_pkg::TIME_W-1:0]  restart_at;

  logic                            charging_on_next;
  logic [DW-1:0]                   duty_reg_next;
  logic [mppt_po_pkg::POWER_W-1:0] last_power_next;
  logic                            climb_up_next;
  logic [mppt_po_pkg::TIME_W-1:0]  restart_at_next;

  logic             cond_start, cond_stop, cond_down, cond_low_sun, cond_reguess;
  logic             need_guess;
  logic [SUM_W-1:0] guess_sum;
  logic [DW-1:0]    guess;
  logic [DW-1:0]    low_base;
  logic             climb_flip;

  function automatic logic [DW-1:0] step_up(input logic [DW-1:0] d,
                                            input logic [mppt_po_pkg::STEP_W-1:0] s);
    logic [CMP_W-1:0] sum;
    sum = CMP_W'(d) + CMP_W'(s);
    if (sum > MAX_C) return MAX_C[DW-1:0];
    return sum[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] step_down(input logic [DW-1:0] d,
                                              input logic [mppt_po_pkg::STEP_W-1:0] s);
    logic [CMP_W-1:0] bound;
    bound = MIN_C + CMP_W'(s);
    if (CMP_W'(d) < bound) return MIN_C[DW-1:0];
    return d - DW'(s);
  endfunction

  // Capture measurement and scale the battery voltage for the guess
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      power_r  <= panel_power_mw;
      bat_r    <= battery_mv;
      pan_r    <= panel_mv;
      pan_ma_r <= panel_ma;
      chg_ma_r <= charge_ma;
      hot_r    <= overtemp;
      now_r    <= now_s;
      prod     <= PROD_W'(battery_mv) * PROD_W'(DUTY_TOP);
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign shifted = {rem, quo[PROD_W-1]};
  assign trial   = shifted - {1'b0, pan_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= prod;
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (shifted >= {1'b0, pan_r}) begin
        rem <= trial[MW-1:0];
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[MW-1:0];
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
    end
  end

  // Decision conditions
  assign cond_start   = (bat_r < cfg.target_mv) && (pan_r > bat_r) && (now_r > restart_at);
  assign cond_stop    = pan_ma_r < cfg.stop_panel_ma;
  assign cond_down    = (bat_r > cfg.target_mv) || (chg_ma_r > cfg.target_ma) || hot_r;
  assign cond_low_sun = pan_ma_r < cfg.low_sun_panel_ma;
  assign cond_reguess = {1'b0, pan_ma_r} > ({1'b0, chg_ma_r} + mppt_po_pkg::SELF_MA);

  assign need_guess = charging_on
                    ? (!cond_stop && !cond_down && cond_low_sun && cond_reguess)
                    : cond_start;

  assign status.need_div = need_guess && (pan_r != '0);
  assign status.div_last = (cnt == CNT_W'(PROD_W - 1));

  // Clamp the guessed duty; a zero panel voltage takes the limit
  assign guess_sum = SUM_W'(quo) + SUM_W'(cfg.init_offset);
  always_comb begin
    if (pan_r == '0 || guess_sum > SUM_W'(GUESS_LIM)) guess = GUESS_LIM[DW-1:0];
    else                                              guess = guess_sum[DW-1:0];
  end

  assign low_base   = cond_reguess ? guess : duty_reg;
  assign climb_flip = last_power > power_r;

  // Next control state for this tick
  always_comb begin
    charging_on_next = charging_on;
    duty_reg_next    = duty_reg;
    last_power_next  = power_r;
    climb_up_next    = climb_up;
    restart_at_next  = restart_at;
    priority if (!charging_on) begin
      if (cond_start) begin
        charging_on_next = 1'b1;
        duty_reg_next    = guess;
      end
    end else if (cond_stop) begin
      charging_on_next = 1'b0;
      duty_reg_next    = '0;
      restart_at_next  = now_r + mppt_po_pkg::TIME_W'(cfg.restart_delay_s);
    end else if (cond_down) begin
      duty_reg_next = step_down(duty_reg, cfg.duty_step);
    end else if (cond_low_sun) begin
      duty_reg_next = low_base;
      if (CMP_W'(low_base) < GUESS_LIM) begin
        duty_reg_next   = step_up(low_base, cfg.duty_step);
        climb_up_next   = 1'b1;
        last_power_next = '0;
      end
    end else begin
      climb_up_next = climb_flip ? !climb_up : climb_up;
      duty_reg_next = climb_up_next ? step_up(duty_reg, cfg.duty_step)
                                    : step_down(duty_reg, cfg.duty_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charging_on <= 1'b0;
      duty_reg    <= '0;
      last_power  <= '0;
      climb_up    <= 1'b1;
      restart_at  <= '0;
    end else if (cmd.update) begin
      charging_on <= charging_on_next;
      duty_reg    <= duty_reg_next;
      last_power  <= last_power_next;
      climb_up    <= climb_up_next;
      restart_at  <= restart_at_next;
    end
  end

  assign duty     = duty_reg;
  assign charging = charging_on;
  assign dir_up   = climb_up;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (pan_r != '0))
    else $error("divider stepping with zero divisor");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && charging_on && cond_stop) |=> (!charging_on && duty_reg == '0))
    else $error("stop did not clear duty and charging");

endmodule

>>> design/mppt_po_ctrl.sv
module mppt_po_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  mppt_po_pkg::dp_status_t  status,
  output mppt_po_pkg::dp_cmd_t     cmd
);

  mppt_po_pkg::state_t state, state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mppt_po_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequence one tick: capture, check, divide if a guess is needed, commit
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      mppt_po_pkg::S_IDLE: begin
        // Hold off transfers while reset is applied
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
        if (cmd.capture) state_next = mppt_po_pkg::S_CHECK;
      end
      mppt_po_pkg::S_CHECK: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = mppt_po_pkg::S_DIVIDE;
        end else begin
          state_next = mppt_po_pkg::S_FINISH;
        end
      end
      mppt_po_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = mppt_po_pkg::S_FINISH;
      end
      mppt_po_pkg::S_FINISH: begin
        // Hold until the previous result has been taken
        if (!out_valid || out_ready) begin
          cmd.update = 1'b1;
          state_next = mppt_po_pkg::S_IDLE;
        end
      end
      default: state_next = mppt_po_pkg::S_IDLE;
    endcase
  end

  // Result slot: set on commit, drop on output transfer
  always_comb begin
    if (cmd.update)                   out_valid_next = 1'b1;
    else if (out_valid && out_ready)  out_valid_next = 1'b0;
    else                              out_valid_next = out_valid;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == mppt_po_pkg::S_FINISH))
    else $error("result raised outside commit");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.div_start, cmd.div_step, cmd.update}))
    else $error("conflicting datapath commands");

endmodule

>>> design/mppt_perturb_observe_charger.sv
// Perturb-and-observe solar charge controller. Each measurement tick accepted on the
// input channel yields one result (duty, charging, dir_up) on the output channel. A
// tick that needs a fresh duty guess (charging start, or low sun with panel current
// above charge current plus self consumption) runs a restoring divider one quotient bit
// per cycle to a 16 + clog2(DUTY_TOP+1)-bit quotient (27 bits at default DUTY_TOP),
// so from accept to the next accept it passes the idle, check, divide and finish states;
// any other tick skips the divide state. The result waits in the output register, and
// the next tick is accepted and worked on meanwhile; its commit holds until that result
// is taken. Registers are written through the configuration channel, which is ready
// whenever reset is low; the input channel is likewise held off during reset.
module mppt_perturb_observe_charger #(
  parameter int unsigned DUTY_TOP = 1024,
  parameter int unsigned DUTY_MAX = 1016,
  parameter int unsigned DUTY_MIN = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mppt_po_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mppt_po_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mppt_po_pkg::POWER_W-1:0]     panel_power_mw,
  input  logic [mppt_po_pkg::MV_W-1:0]        battery_mv,
  input  logic [mppt_po_pkg::MV_W-1:0]        panel_mv,
  input  logic [mppt_po_pkg::MA_W-1:0]        panel_ma,
  input  logic [mppt_po_pkg::MA_W-1:0]        charge_ma,
  input  logic                                overtemp,
  input  logic [mppt_po_pkg::TIME_W-1:0]      now_s,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mppt_po_pkg::DUTY_W-1:0]      duty,
  output logic                                charging,
  output logic                                dir_up
);

  mppt_po_pkg::cfg_t       cfg;
  mppt_po_pkg::dp_cmd_t    cmd;
  mppt_po_pkg::dp_status_t status;

  mppt_po_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mppt_po_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mppt_po_datapath #(
    .DUTY_TOP (DUTY_TOP),
    .DUTY_MAX (DUTY_MAX),
    .DUTY_MIN (DUTY_MIN)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .panel_power_mw (panel_power_mw),
    .battery_mv     (battery_mv),
    .panel_mv       (panel_mv),
    .panel_ma       (panel_ma),
    .charge_ma      (charge_ma),
    .overtemp       (overtemp),
    .now_s          (now_s),
    .duty           (duty),
    .charging       (charging),
    .dir_up         (dir_up)
  );

endmodule
